FILE: src/rdbp_pkg.sv
// Shared types, widths and constants for the random dither bit packer.
// Used by every module of the block; depends on nothing else.
package rdbp_pkg;

	localparam int CHANNEL_BITS = 8;
	localparam int FIELD_W = 8;
	localparam int CHAN_W = (CHANNEL_BITS < FIELD_W) ? CHANNEL_BITS : FIELD_W;
	localparam int SUM_W = CHAN_W + 2;
	localparam int COL_W = CHAN_W + 3;
	localparam int NOISE_W = 14;
	localparam int DARK_W = 12;
	localparam int SHADE_W = 11;
	localparam int GAIN_W = 14;
	localparam logic [GAIN_W-1:0] GAIN_K = 14'd10000;
	localparam int FIRST_SHIFT = 9;
	localparam int MID_SHIFT = 10;
	localparam int NS_W = NOISE_W + SHADE_W;
	localparam int DK_COL_W = DARK_W + COL_W;
	localparam int DK_SUM_W = DARK_W + COL_W + 1;
	localparam int LHS_W = NS_W + MID_SHIFT;
	localparam int RHS_W = DK_SUM_W + GAIN_W;
	localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;

	localparam int IDX_W = 3;
	localparam int CFG_DATA_W = 12;
	localparam logic [IDX_W-1:0] REG_RED_ON = 3'd0;
	localparam logic [IDX_W-1:0] REG_GREEN_ON = 3'd1;
	localparam logic [IDX_W-1:0] REG_BLUE_ON = 3'd2;
	localparam logic [IDX_W-1:0] REG_BLEND_ROWS = 3'd3;
	localparam logic [IDX_W-1:0] REG_DARKNESS = 3'd4;
	localparam logic [IDX_W-1:0] REG_FULL_SHADE = 3'd5;

	localparam int DEPTH = 4;
	localparam int PTR_W = 2;
	localparam int CNT_W = 3;

	typedef struct packed {
		logic red_on;
		logic green_on;
		logic blue_on;
		logic blend_rows;
		logic [DARK_W-1:0] darkness;
		logic [SHADE_W-1:0] full_shade;
	} cfg_t;

	typedef struct packed {
		logic [FIELD_W-1:0] red_top;
		logic [FIELD_W-1:0] green_top;
		logic [FIELD_W-1:0] blue_top;
		logic [FIELD_W-1:0] red_bottom;
		logic [FIELD_W-1:0] green_bottom;
		logic [FIELD_W-1:0] blue_bottom;
		logic [NOISE_W-1:0] noise_first;
		logic [NOISE_W-1:0] noise_mid;
		logic last_pixel;
	} pixel_t;

	typedef struct packed {
		logic first;
		logic mid;
		logic last;
	} dots_t;

	typedef struct packed {
		logic [7:0] packed_byte;
		logic last_byte;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t r0;
		result_t r1;
	} push_t;

endpackage

FILE: src/rdbp_cfg.sv
// Configuration registers of the random dither bit packer.
// Depends on rdbp_pkg for the register indexes and the cfg_t type.
module rdbp_cfg import rdbp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red_on <= 1'b1;
			cfg_q.green_on <= 1'b0;
			cfg_q.blue_on <= 1'b0;
			cfg_q.blend_rows <= 1'b0;
			cfg_q.darkness <= DARK_W'(256);
			cfg_q.full_shade <= SHADE_W'(765);
		end else if (wr_en) begin
			case (wr_index)
				REG_RED_ON: cfg_q.red_on <= wr_data[0];
				REG_GREEN_ON: cfg_q.green_on <= wr_data[0];
				REG_BLUE_ON: cfg_q.blue_on <= wr_data[0];
				REG_BLEND_ROWS: cfg_q.blend_rows <= wr_data[0];
				REG_DARKNESS: cfg_q.darkness <= wr_data[DARK_W-1:0];
				REG_FULL_SHADE: cfg_q.full_shade <= wr_data[SHADE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: src/rdbp_shade.sv
// Shade and threshold pipeline: input register, products, then the two dot compares.
// Depends on rdbp_pkg for pixel_t, cfg_t, dots_t and the arithmetic widths.
module rdbp_shade import rdbp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_valid,
	input  pixel_t pix,
	input  cfg_t cfg,
	output logic dots_valid,
	output dots_t dots
);

	pixel_t pix_s1;
	logic valid_s1;

	logic [COL_W-1:0] prev_col_q;
	logic [NS_W-1:0] nf_ms_s2;
	logic [NS_W-1:0] nm_ms_s2;
	logic [DK_COL_W-1:0] dk_col_s2;
	logic [DK_SUM_W-1:0] dk_sum_s2;
	logic last_s2;
	logic valid_s2;

	dots_t dots_s3;
	logic valid_s3;

	logic [SUM_W-1:0] w_top;
	logic [SUM_W-1:0] w_bot;
	logic [COL_W-1:0] col;
	logic [COL_W:0] pair_sum;
	logic [CMP_W-1:0] lhs_first;
	logic [CMP_W-1:0] rhs_first;
	logic [CMP_W-1:0] lhs_mid;
	logic [CMP_W-1:0] rhs_mid;

	function automatic logic [SUM_W-1:0] weigh(input cfg_t c, input logic [FIELD_W-1:0] r,
			input logic [FIELD_W-1:0] g, input logic [FIELD_W-1:0] b);
		logic [SUM_W-1:0] acc;
		acc = '0;
		if (c.red_on) acc = acc + SUM_W'(r[CHAN_W-1:0]);
		if (c.green_on) acc = acc + SUM_W'(g[CHAN_W-1:0]);
		if (c.blue_on) acc = acc + SUM_W'(b[CHAN_W-1:0]);
		return acc;
	endfunction

	always_comb begin
		w_top = weigh(cfg, pix_s1.red_top, pix_s1.green_top, pix_s1.blue_top);
		w_bot = weigh(cfg, pix_s1.red_bottom, pix_s1.green_bottom, pix_s1.blue_bottom);
		col = cfg.blend_rows ? (COL_W'(w_top) + COL_W'(w_bot)) : {w_top, 1'b0};
		pair_sum = (COL_W + 1)'(prev_col_q) + (COL_W + 1)'(col);
	end

	always_comb begin
		lhs_first = CMP_W'({nf_ms_s2, {FIRST_SHIFT{1'b0}}});
		rhs_first = CMP_W'(dk_col_s2) * CMP_W'(GAIN_K);
		lhs_mid = CMP_W'({nm_ms_s2, {MID_SHIFT{1'b0}}});
		rhs_mid = CMP_W'(dk_sum_s2) * CMP_W'(GAIN_K);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			prev_col_q <= '0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			if (valid_s1) begin
				prev_col_q <= col;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1 <= pix;
			nf_ms_s2 <= NS_W'(pix_s1.noise_first * cfg.full_shade);
			nm_ms_s2 <= NS_W'(pix_s1.noise_mid * cfg.full_shade);
			dk_col_s2 <= DK_COL_W'(cfg.darkness * col);
			dk_sum_s2 <= DK_SUM_W'(cfg.darkness * pair_sum);
			last_s2 <= pix_s1.last_pixel;
			dots_s3.first <= lhs_first < rhs_first;
			dots_s3.mid <= lhs_mid < rhs_mid;
			dots_s3.last <= last_s2;
		end
	end

	assign dots_valid = valid_s3;
	assign dots = dots_s3;

endmodule

FILE: src/rdbp_pack.sv
// Dot packer: places each pixel's dots into the byte being built and emits bytes.
// Depends on rdbp_pkg for dots_t and push_t.
module rdbp_pack import rdbp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  dots_t dots,
	output push_t push
);

	logic [1:0] slot_q;
	logic have_prev_q;
	logic [7:0] part_q;

	logic [1:0] prev_slot;
	logic [7:0] with_mid;
	logic [7:0] base;
	logic [7:0] with_first;
	logic flush_held;

	always_comb begin
		prev_slot = slot_q - 2'd1;
		with_mid = part_q;
		if (have_prev_q && dots.mid) begin
			with_mid[{~prev_slot, 1'b0}] = 1'b1;
		end
		flush_held = have_prev_q && (slot_q == 2'd0);
		base = flush_held ? 8'd0 : with_mid;
		with_first = base;
		if (dots.first) begin
			with_first[{~slot_q, 1'b1}] = 1'b1;
		end
	end

	always_comb begin
		push.n = 2'd0;
		push.r0.packed_byte = with_mid;
		push.r0.last_byte = 1'b0;
		push.r1.packed_byte = with_first;
		push.r1.last_byte = 1'b1;
		if (fire) begin
			if (flush_held) begin
				push.n = dots.last ? 2'd2 : 2'd1;
			end else if (dots.last) begin
				push.n = 2'd1;
				push.r0.packed_byte = with_first;
				push.r0.last_byte = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= 2'd0;
			have_prev_q <= 1'b0;
			part_q <= 8'd0;
		end else if (fire) begin
			if (dots.last) begin
				slot_q <= 2'd0;
				have_prev_q <= 1'b0;
				part_q <= 8'd0;
			end else begin
				slot_q <= slot_q + 2'd1;
				have_prev_q <= 1'b1;
				part_q <= with_first;
			end
		end
	end

`ifndef SYNTHESIS
	a_fresh_row_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!have_prev_q |-> (slot_q == 2'd0 && part_q == 8'd0))
		else $error("packer holds dots without a previous pixel");
	a_row_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && dots.last) |=> (!have_prev_q && slot_q == 2'd0))
		else $error("packer state not cleared after row end");
`endif

endmodule

FILE: src/rdbp_fifo.sv
// Result queue: takes up to two bytes per cycle, hands out one per request.
// Depends on rdbp_pkg for result_t, push_t and the queue depth.
module rdbp_fifo import rdbp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  push_t push,
	input  logic out_ready,
	output logic out_valid,
	output result_t out_data,
	output logic [CNT_W-1:0] count
);

	result_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic pop;

	assign out_valid = count_q != '0;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push.n) - CNT_W'(pop);
		end
	end

	assign out_data = mem_q[rd_ptr_q];
	assign count = count_q;

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(CNT_W + 1)'(count_q) + (CNT_W + 1)'(push.n) <= (CNT_W + 1)'(DEPTH))
		else $error("result queue overflow");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q == $past(count_q) + CNT_W'($past(push.n)) - CNT_W'($past(pop)))
		else $error("result queue count out of step");
`endif

endmodule

FILE: src/random_dither_bit_packer.sv
// Random threshold dither and dot packer for one raster row of a printer plane.
// Input requests enter on the s_ channel, packed bytes leave on the m_ channel, and
// the six control registers are written over the cfg_ channel (always ready).
// s_tdata holds one pixel column with its two noise values; s_tlast marks the row's
// last pixel. Each pixel gives two dots, four pixels fill a byte, first dot in the MSB.
// m_tlast marks the final, possibly partly filled, byte of a row.
// Throughput is one pixel per cycle while s_tready is high: an input register, a
// product stage and a compare stage feed the packer, whose bytes pass through a
// four-entry result queue to m_tdata. A row end that also flushes a held full byte
// gives two bytes from one pixel, both buffered in that queue. s_tready falls only
// when that queue cannot take two more bytes, which happens when the receiver stalls;
// the pipeline then freezes and no data is lost.
// Reset clears the row state, the queue and the pipeline, and sets the registers to
// red only, no row blend, darkness 1.0 and full-scale shade 765.
// Configuration should be written only while no pixel is in flight.
module random_dither_bit_packer import rdbp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// red_top, green_top, blue_top, red_bottom, green_bottom, blue_bottom,
	// noise_first, noise_mid, then zero padding.
	input  logic [79:0] s_tdata,
	input  logic s_tlast,
	output logic m_tvalid,
	input  logic m_tready,
	// packed_byte.
	output logic [7:0] m_tdata,
	output logic m_tlast,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg;
	pixel_t pix;
	dots_t dots;
	logic dots_valid;
	logic adv;
	push_t push;
	result_t out_data;
	logic [CNT_W-1:0] fifo_count;

	assign cfg_ready = 1'b1;

	assign pix.red_top = s_tdata[7:0];
	assign pix.green_top = s_tdata[15:8];
	assign pix.blue_top = s_tdata[23:16];
	assign pix.red_bottom = s_tdata[31:24];
	assign pix.green_bottom = s_tdata[39:32];
	assign pix.blue_bottom = s_tdata[47:40];
	assign pix.noise_first = s_tdata[61:48];
	assign pix.noise_mid = s_tdata[75:62];
	assign pix.last_pixel = s_tlast;

	assign adv = !(dots_valid && (fifo_count > CNT_W'(DEPTH - 2)));
	assign s_tready = adv;

	rdbp_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cfg_valid && cfg_ready),
		.wr_index(cfg_index),
		.wr_data(cfg_data),
		.cfg(cfg)
	);

	rdbp_shade u_shade (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(s_tvalid && s_tready),
		.pix(pix),
		.cfg(cfg),
		.dots_valid(dots_valid),
		.dots(dots)
	);

	rdbp_pack u_pack (
		.clk(clk),
		.arst_n(arst_n),
		.fire(dots_valid && adv),
		.dots(dots),
		.push(push)
	);

	rdbp_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.out_ready(m_tready),
		.out_valid(m_tvalid),
		.out_data(out_data),
		.count(fifo_count)
	);

	assign m_tdata = out_data.packed_byte;
	assign m_tlast = out_data.last_byte;

endmodule
